// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types and constants of the sensor frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    localparam int unsigned PAYLOAD_BYTES_DEF = 30;

    localparam logic [7:0] FRAME_HEADER = 8'h16;

    // payload positions of the readings, high byte first
    localparam int unsigned N_READ_BYTES = 6;
    localparam int unsigned READ_POS [N_READ_BYTES] = '{3, 4, 7, 8, 11, 12};

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_SUM_ERR = 2'd1,
        ST_LEN_ERR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_CHECK  = 4'b1000
    } t_phase;

endpackage

`default_nettype wire

// ===== rtl/sensor_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_deframer
// Takes one received byte per item, finds frames that open with header 0x16
// followed by a length byte, the payload and a check byte whose 8-bit sum with
// the rest is zero. Each check byte gives one result with the status and, on a
// good sum, three big-endian 16-bit readings from payload bytes 3-4, 7-8 and
// 11-12, zero otherwise; a length byte above PAYLOAD_BYTES gives a length-error
// result and a new header search. The block takes one byte every cycle unless
// a result stalled on the output holds it; a result shows on the output once
// its check or length byte has passed from the input register into the result
// register. Only the six payload bytes that feed the readings are kept, cleared
// at reset, so a short frame reads bytes left by earlier frames.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_deframer #(
    parameter int unsigned PAYLOAD_BYTES = sfd_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_pm25_value,
    output logic [15:0]      o_pm1_value,
    output logic [15:0]      o_pm10_value
);

    localparam int unsigned LW = $clog2(PAYLOAD_BYTES + 1);
    localparam int unsigned NB = sfd_pkg::N_READ_BYTES;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // parser state
    sfd_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_sum, n_sum;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_idx, n_idx;
    logic [7:0]      r_pl [NB];
    logic [7:0]      n_pl [NB];

    // result register
    logic            r_out_vld;
    sfd_pkg::t_status r_status, n_status;
    logic [15:0]     r_pm25, r_pm1, r_pm10;
    logic [15:0]     n_pm25, n_pm1, n_pm10;

    logic gen;
    logic out_free;
    logic adv;
    logic fire;
    logic emit;
    logic [7:0] sum_add;
    logic [LW-1:0] idx_inc;

    assign out_free = !r_out_vld || !i_stall;
    assign adv      = !gen || out_free;
    assign fire     = r_in_vld && adv;
    assign emit     = fire && gen;
    assign o_stall  = r_in_vld && !adv;

    assign sum_add = r_sum + r_in_byte;
    assign idx_inc = r_idx + LW'(1);

    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_len    = r_len;
        n_idx    = r_idx;
        n_pl     = r_pl;
        gen      = 1'b0;
        n_status = sfd_pkg::ST_GOOD;
        n_pm25   = '0;
        n_pm1    = '0;
        n_pm10   = '0;
        unique case (r_phase)
            sfd_pkg::PH_HEADER: begin
                n_sum = r_in_byte;
                if (r_in_byte == sfd_pkg::FRAME_HEADER) begin
                    n_phase = sfd_pkg::PH_LENGTH;
                end
            end
            sfd_pkg::PH_LENGTH: begin
                n_sum = sum_add;
                if (r_in_byte > 8'(PAYLOAD_BYTES)) begin
                    n_phase  = sfd_pkg::PH_HEADER;
                    gen      = 1'b1;
                    n_status = sfd_pkg::ST_LEN_ERR;
                end else begin
                    n_len   = r_in_byte[LW-1:0];
                    n_idx   = '0;
                    n_phase = (r_in_byte != 8'd0) ? sfd_pkg::PH_DATA : sfd_pkg::PH_CHECK;
                end
            end
            sfd_pkg::PH_DATA: begin
                n_sum = sum_add;
                for (int k = 0; k < NB; k++) begin
                    if (r_idx == LW'(sfd_pkg::READ_POS[k])) begin
                        n_pl[k] = r_in_byte;
                    end
                end
                n_idx = idx_inc;
                if (idx_inc >= r_len) begin
                    n_phase = sfd_pkg::PH_CHECK;
                end
            end
            sfd_pkg::PH_CHECK: begin
                n_sum   = sum_add;
                n_phase = sfd_pkg::PH_HEADER;
                gen     = 1'b1;
                if (sum_add == 8'd0) begin
                    n_status = sfd_pkg::ST_GOOD;
                    n_pm25   = {r_pl[0], r_pl[1]};
                    n_pm1    = {r_pl[2], r_pl[3]};
                    n_pm10   = {r_pl[4], r_pl[5]};
                end else begin
                    n_status = sfd_pkg::ST_SUM_ERR;
                end
            end
            default: begin
                n_phase = sfd_pkg::PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!r_in_vld || adv) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_in_vld || adv) && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfd_pkg::PH_HEADER;
            r_sum   <= '0;
            r_len   <= '0;
            r_idx   <= '0;
            for (int k = 0; k < NB; k++) begin
                r_pl[k] <= '0;
            end
        end else if (fire) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_pl    <= n_pl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= n_status;
            r_pm25   <= n_pm25;
            r_pm1    <= n_pm1;
            r_pm10   <= n_pm10;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_status     = r_status;
    assign o_pm25_value = r_pm25;
    assign o_pm1_value  = r_pm1;
    assign o_pm10_value = r_pm10;

endmodule

`default_nettype wire

// ===== rtl/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// sfd_checker
// port-level checks of the sensor frame deframer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_status,
    input wire logic [15:0] o_pm25_value,
    input wire logic [15:0] o_pm1_value,
    input wire logic [15:0] o_pm10_value
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_pm25_value)
            && $stable(o_pm1_value) && $stable(o_pm10_value))
        else $error("stalled result changed");

    // error results carry no readings
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != sfd_pkg::ST_GOOD) |->
            (o_pm25_value == 16'd0) && (o_pm1_value == 16'd0) && (o_pm10_value == 16'd0))
        else $error("error result with nonzero readings");

    // no result and no stall right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or stall after reset");

    // only defined status codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == sfd_pkg::ST_GOOD) || (o_status == sfd_pkg::ST_SUM_ERR)
            || (o_status == sfd_pkg::ST_LEN_ERR))
        else $error("undefined status code");

    // an input byte cannot be stalled without one held in front of it
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output free");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_pm25_value (o_pm25_value),
    .o_pm1_value  (o_pm1_value),
    .o_pm10_value (o_pm10_value)
);

`default_nettype wire

// ===== tb/sfd_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfd_monitor
// Watches both channels of the sensor frame deframer, runs its own frame
// parser on every accepted byte, queues the results it predicts and compares
// each accepted result, field by field, with the oldest one still queued.
// ----------------------------------------------------------------------------

module sfd_monitor #(
    parameter int unsigned PAYLOAD_BYTES = sfd_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_pm25_value,
    input  logic [15:0] i_pm1_value,
    input  logic [15:0] i_pm10_value,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        sfd_pkg::t_status status;
        logic [15:0]      pm25;
        logic [15:0]      pm1;
        logic [15:0]      pm10;
    } t_frame_result;

    t_frame_result frames_due [$];

    sfd_pkg::t_phase phase;
    logic [7:0] frame_sum;
    logic [7:0] frame_len;
    logic [7:0] byte_idx;
    logic [7:0] payload [PAYLOAD_BYTES];
    int         errors = 0;

    assign o_errors = errors;

    function automatic logic [15:0] reading_at(input int hi);
        return {payload[hi], payload[hi + 1]};
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        t_frame_result r;
        r = '0;
        case (phase)
            sfd_pkg::PH_HEADER: begin
                frame_sum = b;
                if (b == sfd_pkg::FRAME_HEADER) phase = sfd_pkg::PH_LENGTH;
            end
            sfd_pkg::PH_LENGTH: begin
                frame_sum = frame_sum + b;
                if (b <= PAYLOAD_BYTES) begin
                    frame_len = b;
                    byte_idx  = '0;
                    phase     = (b != 8'd0) ? sfd_pkg::PH_DATA : sfd_pkg::PH_CHECK;
                end else begin
                    phase    = sfd_pkg::PH_HEADER;
                    r.status = sfd_pkg::ST_LEN_ERR;
                    frames_due.push_back(r);
                end
            end
            sfd_pkg::PH_DATA: begin
                frame_sum = frame_sum + b;
                if (byte_idx < PAYLOAD_BYTES) payload[byte_idx] = b;
                byte_idx = byte_idx + 8'd1;
                if (byte_idx >= frame_len) phase = sfd_pkg::PH_CHECK;
            end
            default: begin
                frame_sum = frame_sum + b;
                phase     = sfd_pkg::PH_HEADER;
                if (frame_sum == 8'd0) begin
                    r.status = sfd_pkg::ST_GOOD;
                    r.pm25   = reading_at(3);
                    r.pm1    = reading_at(7);
                    r.pm10   = reading_at(11);
                end else begin
                    r.status = sfd_pkg::ST_SUM_ERR;
                end
                frames_due.push_back(r);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            phase     = sfd_pkg::PH_HEADER;
            frame_sum = '0;
            frame_len = '0;
            byte_idx  = '0;
            foreach (payload[k]) payload[k] = '0;
            frames_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: status expected none actual %0d", $time, i_status);
                    errors++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("status", 16'(want.status), 16'(i_status));
                    check_field("pm25_value", want.pm25, i_pm25_value);
                    check_field("pm1_value", want.pm1, i_pm1_value);
                    check_field("pm10_value", want.pm10, i_pm10_value);
                end
            end
            if (i_in_valid && !i_in_stall) parse_byte(i_rx_byte);
        end
        o_pending <= frames_due.size();
    end

endmodule

// ===== tb/sensor_frame_deframer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_frame_deframer_test
// Feeds the deframer a short directed set of frames (empty, over-long, bad
// sum, full readings) and then random frames mixed with noise and broken
// frames, with random gaps and stalls on both sides, one long receiver
// hold-off and a full drain midway; the monitor checks every result.
// ----------------------------------------------------------------------------

module sensor_frame_deframer_test;

    localparam int unsigned PAYLOAD_BYTES = sfd_pkg::PAYLOAD_BYTES_DEF;
    localparam int N_ITEMS      = 650;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 20;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_pm25_value;
    logic [15:0] o_pm1_value;
    logic [15:0] o_pm10_value;

    int n_errors;
    int n_pending;
    int n_sent      = 0;
    int tx_calm     = 0;
    int rx_calm     = 0;
    bit rx_hold_req = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sensor_frame_deframer #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_pm25_value(o_pm25_value),
        .o_pm1_value (o_pm1_value),
        .o_pm10_value(o_pm10_value)
    );

    sfd_monitor #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_rx_byte   (i_rx_byte),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_status    (o_status),
        .i_pm25_value(o_pm25_value),
        .i_pm1_value (o_pm1_value),
        .i_pm10_value(o_pm10_value),
        .o_errors    (n_errors),
        .o_pending   (n_pending)
    );

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'hFF;
            1:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (tx_calm > 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        n_sent++;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] body [$],
                              input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] check;
        sum = sfd_pkg::FRAME_HEADER + len;
        send_byte(sfd_pkg::FRAME_HEADER);
        send_byte(len);
        if (len <= PAYLOAD_BYTES) begin
            foreach (body[k]) begin
                sum = sum + body[k];
                send_byte(body[k]);
            end
            check = -sum;
            if (bad_sum) check = check ^ 8'($urandom_range(1, 255));
            send_byte(check);
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
    endtask

    // receiver: random stall before a result, with calm runs and one long hold-off
    initial begin
        int n;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                n = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else if (rx_calm > 0) begin
                n = 0;
                rx_calm--;
            end else begin
                n = $urandom_range(0, 13);
                if ($urandom_range(0, 7) == 0) rx_calm = 10;
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // watchdog on cycles with no item accepted on either side
    initial begin
        int idle;
        idle = 0;
        wait (i_rst_n);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [7:0] body [$];
        logic [7:0] len;
        int         kind;
        bit         held;
        bit         paused;
        held   = 1'b0;
        paused = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        send_byte(8'hFF);
        body.delete();
        send_frame(8'd0, body, 1'b0);
        send_frame(8'(PAYLOAD_BYTES + 1), body, 1'b0);
        send_frame(8'hFF, body, 1'b0);
        body.push_back(8'h00);
        send_frame(8'd1, body, 1'b1);
        body.delete();
        for (int k = 0; k < 13; k++) body.push_back(k[0] ? 8'h00 : 8'hFF);
        send_frame(8'd13, body, 1'b0);

        // random frames, noise and broken frames
        while (n_sent < N_ITEMS) begin
            if (tx_calm > 0) tx_calm--;
            else if ($urandom_range(0, 5) == 0) tx_calm = 3;

            if (!held && n_sent > 200) begin
                held = 1'b1;
                tx_calm = 6;
                rx_hold_req = 1'b1;
            end
            if (!paused && n_sent > 420) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                wait_drained();
            end

            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                repeat ($urandom_range(1, 3)) send_byte(pick_byte());
            end else begin
                if (kind < 14) len = 8'($urandom_range(PAYLOAD_BYTES + 1, 255));
                else if ($urandom_range(0, 9) < 6) len = 8'($urandom_range(13, PAYLOAD_BYTES));
                else len = 8'($urandom_range(0, 12));
                body.delete();
                if (len <= PAYLOAD_BYTES) repeat (len) body.push_back(pick_byte());
                send_frame(len, body, kind < 24);
            end
        end
        i_valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
